// File: rtl/positional_list_insert_get_unit_defines.svh
// Assertion macros shared by the list unit modules.
`ifndef POSITIONAL_LIST_INSERT_GET_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_GET_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLIG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLIG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/plig_pkg.sv
// Shared types and constants of the positional list unit.
package plig_pkg;

    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

    localparam logic CMD_READ   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;      // capture the input word, clear the result
        logic issue_read;   // read the entry at position
        logic shift_start;  // point at the list end, read the last entry
        logic shift_step;   // move one entry up, read the next one down
        logic write_val;    // store the new value, bump the length
        logic cap_read;     // capture read data into the result
        logic load_out;     // copy the result into the output register
    } plig_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;          // command cannot be carried out
        logic is_insert;    // captured command is an insert
        logic need_shift;   // insert lands inside the list
        logic shift_last;   // shift pointer has reached the position
    } plig_stat_t;

endpackage

// File: rtl/positional_list_insert_get_unit.sv
// Top level of the positional list unit: controller plus datapath.
//
// Keeps an ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel (in_valid/in_ready): one word carries command, position
// and value. command 0 reads the entry at 1-based position, command 1
// inserts value at position 1..length+1, moving later entries up.
// Output channel (out_valid/out_ready): one word per command with status
// (0 done, 1 error), read_value (zero unless a read succeeds) and count,
// the list length after the command, low 6 bits.
// From input accept to output valid, a word goes through decode; an
// error then goes straight to the response, a read waits for the store
// read data, and an insert writes after any move of entries. The move loop
// copies one entry per cycle through the single-port-pair entry store,
// which sets the worst case. One word is worked on at a time; a new word
// is taken as soon as the previous result sits in the output register.
// A stalled receiver holds the result in the output register; the next
// word runs up to its result and waits there for the slot to free up.
// Reset clears the length and the handshake state; the entry store is
// not cleared, since only written entries are ever read.
module positional_list_insert_get_unit
    import plig_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      command,
    input  logic        [POS_W-1:0]   position,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      status,
    output logic signed [DATA_W-1:0]  read_value,
    output logic        [COUNT_W-1:0] count
);

    plig_cmd_t  cmd;
    plig_stat_t stat;

    // Sequence each word: decode, read or move entries and write, respond.
    plig_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the list, the length and the result word.
    plig_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .position   (position),
        .value      (value),
        .cmd        (cmd),
        .stat       (stat),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

endmodule

// File: rtl/plig_datapath.sv
// Datapath of the list unit: entry store, length, shift pointer, result registers.
`include "positional_list_insert_get_unit_defines.svh"

module plig_datapath
    import plig_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     command,
    input  logic        [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] value,
    input  plig_cmd_t                cmd,
    output plig_stat_t               stat,
    output logic                     status,
    output logic signed [DATA_W-1:0] read_value,
    output logic        [COUNT_W-1:0] count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    logic signed [DATA_W-1:0] rdata_reg;

    logic                     cmd_reg;
    logic        [POS_W-1:0]  pos_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic        [LW-1:0]     len_reg;
    logic        [LW-1:0]     len_next;
    logic        [IW-1:0]     k_reg;
    logic        [IW-1:0]     k_next;

    logic                     res_status_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic                     status_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic        [COUNT_W-1:0] count_reg;

    logic [CW-1:0] pos_w, len_w, k_w;
    logic [CW-1:0] pos_m1, len_m1, k_m1, k_m2, len_p1;
    logic          rd_ok, ins_ok;
    logic          mem_re, mem_we;
    logic [IW-1:0] raddr, waddr;
    logic signed [DATA_W-1:0] wdata;

    assign pos_w  = CW'(pos_reg);
    assign len_w  = CW'(len_reg);
    assign k_w    = CW'(k_reg);
    assign pos_m1 = pos_w - CW'(1);
    assign len_m1 = len_w - CW'(1);
    assign len_p1 = len_w + CW'(1);
    assign k_m1   = k_w - CW'(1);
    assign k_m2   = k_w - CW'(2);

    assign rd_ok  = (pos_w != '0) && (pos_w <= len_w);
    assign ins_ok = (len_w < CW'(CAPACITY)) && (pos_w != '0) && (pos_w <= len_p1);

    always_comb
    begin
        stat.err        = (cmd_reg == CMD_READ) ? !rd_ok : !ins_ok;
        stat.is_insert  = (cmd_reg == CMD_INSERT);
        stat.need_shift = (pos_w <= len_w);
        stat.shift_last = (k_w == pos_w);
    end

    // Store port selection: one read and one write per cycle.
    always_comb
    begin
        mem_re = cmd.issue_read || cmd.shift_start || (cmd.shift_step && !stat.shift_last);
        priority if (cmd.issue_read)
        begin
            raddr = pos_m1[IW-1:0];
        end
        else if (cmd.shift_start)
        begin
            raddr = len_m1[IW-1:0];
        end
        else
        begin
            raddr = k_m2[IW-1:0];
        end
        mem_we = cmd.shift_step || cmd.write_val;
        if (cmd.shift_step)
        begin
            waddr = k_reg;
            wdata = rdata_reg;
        end
        else
        begin
            waddr = pos_m1[IW-1:0];
            wdata = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            list_mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= list_mem[raddr];
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.write_val)
        begin
            len_next = len_p1[LW-1:0];
        end
        k_next = k_reg;
        if (cmd.shift_start)
        begin
            k_next = len_w[IW-1:0];
        end
        else if (cmd.shift_step)
        begin
            k_next = k_m1[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            k_reg   <= '0;
        end
        else
        begin
            len_reg <= len_next;
            k_reg   <= k_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg        <= command;
            pos_reg        <= position;
            val_reg        <= value;
            res_status_reg <= STATUS_ERR;
            res_value_reg  <= '0;
        end
        if (cmd.cap_read)
        begin
            res_status_reg <= STATUS_OK;
            res_value_reg  <= rdata_reg;
        end
        if (cmd.write_val)
        begin
            res_status_reg <= STATUS_OK;
        end
        if (cmd.load_out)
        begin
            status_reg     <= res_status_reg;
            read_value_reg <= res_value_reg;
            count_reg      <= len_w[COUNT_W-1:0];
        end
    end

    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;

    `PLIG_ASSERT_NOW(a_len_bound, clk, rst_n, 1'b1, len_w <= CW'(CAPACITY),
        "list length above capacity")
    `PLIG_ASSERT_NEXT(a_len_bump, clk, rst_n, cmd.write_val,
        len_reg == $past(len_reg) + LW'(1), "insert did not bump the length")
    `PLIG_ASSERT_NOW(a_shift_range, clk, rst_n, cmd.shift_step,
        (k_w >= pos_w) && (k_w < CW'(CAPACITY)), "shift pointer out of range")

endmodule

// File: rtl/plig_ctrl.sv
// Controller state machine of the list unit.
`include "positional_list_insert_get_unit_defines.svh"

module plig_ctrl
    import plig_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  plig_stat_t stat,
    output plig_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DECIDE    = 6'b000010,
        S_SHIFT     = 6'b000100,
        S_WRITE     = 6'b001000,
        S_READ_WAIT = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (stat.err)
                begin
                    state_next = S_RESP;
                end
                else if (!stat.is_insert)
                begin
                    cmd.issue_read = 1'b1;
                    state_next     = S_READ_WAIT;
                end
                else if (stat.need_shift)
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_val = 1'b1;
                state_next    = S_RESP;
            end
            S_READ_WAIT:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `PLIG_ASSERT_NEXT(a_accept_decide, clk, rst_n, in_valid && in_ready,
        state_reg == S_DECIDE, "accepted word did not reach decode")
    `PLIG_ASSERT_NOW(a_load_free, clk, rst_n, cmd.load_out, out_free,
        "result loaded over a pending word")
    `PLIG_ASSERT_NEXT(a_shift_end, clk, rst_n, cmd.shift_step && stat.shift_last,
        state_reg == S_WRITE, "shift end did not lead to the write")

endmodule
